// ----- rtl/rotation_matrix_from_euler_defines.svh -----
// Assertion macros shared by the euler-to-matrix block
`ifndef ROTATION_MATRIX_FROM_EULER_DEFINES_SVH
`define ROTATION_MATRIX_FROM_EULER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define RMFE_ASSERT_IMP(label, clk_s, rst_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define RMFE_ASSERT_NEXT(label, clk_s, rst_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmfe_pkg.sv -----
// Shared constants and helpers for the euler-to-matrix block
package rmfe_pkg;

    localparam int PHASE_BITS = 32;
    localparam int ACC_BITS   = 34;
    localparam int TDATA_IN_BITS  = 56;
    localparam int TDATA_OUT_BITS = 144;

    localparam logic signed [35:0] RAD_TO_PHASE = 36'sd10937044409;
    localparam logic signed [35:0] DEG_TO_PHASE = 36'sd12216795864;
    localparam logic signed [ACC_BITS-1:0] GAIN_Q30 = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] tab [32];
        tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
                32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
                32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
                32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return tab[idx[4:0]];
    endfunction

endpackage

// ----- rtl/rmfe_phase.sv -----
// Angle to binary phase conversion stage, two register levels
module rmfe_phase
    import rmfe_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic                  mode,
    input  logic signed [15:0]    angle,
    input  logic                  negate,
    output logic [PHASE_BITS-1:0] phase
);

    logic signed [51:0]     prod_reg;
    logic                   neg_reg;
    logic signed [51:0]     prod_next;
    logic [PHASE_BITS-1:0]  ph_raw;
    logic [PHASE_BITS-1:0]  ph_rnd;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_next;

    // Scale the angle to 2^-48 turn units
    always_comb
    begin
        prod_next = 52'(angle) * 52'(mode ? DEG_TO_PHASE : RAD_TO_PHASE);
    end

    // Round to the phase, then to ANGLE_BITS bits, then negate if asked
    always_comb
    begin
        ph_raw = PHASE_BITS'((prod_reg + 52'sd32768) >>> 16);
        if (ANGLE_BITS >= PHASE_BITS)
        begin
            ph_rnd = ph_raw;
        end
        else
        begin
            ph_rnd = (ph_raw + (PHASE_BITS'(1) << (PHASE_BITS - ANGLE_BITS - 1)))
                     & ~((PHASE_BITS'(1) << (PHASE_BITS - ANGLE_BITS)) - PHASE_BITS'(1));
        end
        phase_next = neg_reg ? (PHASE_BITS'(0) - ph_rnd) : ph_rnd;
    end

    // Advance both levels
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            neg_reg   <= negate;
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ----- rtl/rmfe_cordic_cell.sv -----
// One CORDIC rotation cell for three angles side by side
module rmfe_cordic_cell
    import rmfe_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [ACC_BITS-1:0] x_in [3],
    input  logic signed [ACC_BITS-1:0] y_in [3],
    input  logic signed [ACC_BITS-1:0] z_in [3],
    input  logic [1:0]                 q_in [3],
    output logic signed [ACC_BITS-1:0] x_out [3],
    output logic signed [ACC_BITS-1:0] y_out [3],
    output logic signed [ACC_BITS-1:0] z_out [3],
    output logic [1:0]                 q_out [3]
);

    localparam logic signed [ACC_BITS-1:0] ANG = ACC_BITS'(atan_turn(STAGE));

    logic signed [ACC_BITS-1:0] x_reg [3];
    logic signed [ACC_BITS-1:0] y_reg [3];
    logic signed [ACC_BITS-1:0] z_reg [3];
    logic [1:0]                 q_reg [3];

    // Rotate toward zero residual and hand on to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (!z_in[k][ACC_BITS-1])
                begin
                    x_reg[k] <= x_in[k] - (y_in[k] >>> STAGE);
                    y_reg[k] <= y_in[k] + (x_in[k] >>> STAGE);
                    z_reg[k] <= z_in[k] - ANG;
                end
                else
                begin
                    x_reg[k] <= x_in[k] + (y_in[k] >>> STAGE);
                    y_reg[k] <= y_in[k] - (x_in[k] >>> STAGE);
                    z_reg[k] <= z_in[k] + ANG;
                end
                q_reg[k] <= q_in[k];
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign q_out = q_reg;

endmodule

// ----- rtl/rmfe_matrix.sv -----
// Product stages that form the nine matrix entries from sines and cosines
module rmfe_matrix
    import rmfe_pkg::*;
#(
    parameter int COEF_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [COEF_BITS:0]   si,
    input  logic signed [COEF_BITS:0]   ci,
    input  logic signed [COEF_BITS:0]   sj,
    input  logic signed [COEF_BITS:0]   cj,
    input  logic signed [COEF_BITS:0]   sh,
    input  logic signed [COEF_BITS:0]   ch,
    output logic signed [15:0]          m [9]
);

    localparam int CF = COEF_BITS - 2;
    localparam int W  = COEF_BITS + 1;
    localparam int PW = 2 * W + 2;

    function automatic logic signed [W:0] rmul(input logic signed [W:0] a,
                                               input logic signed [W:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        p = p + (PW'(1) <<< (CF - 1));
        return (W + 1)'(p >>> CF);
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [W+1:0] v);
        logic signed [W+15:0] t;
        if (CF >= 14)
        begin
            t = (W + 16)'(v);
            if (CF > 14)
            begin
                t = (t + ((W + 16)'(1) <<< (CF - 15))) >>> (CF - 14);
            end
        end
        else
        begin
            t = (W + 16)'(v) <<< (14 - CF);
        end
        if (t > (W + 16)'(16384))
        begin
            t = (W + 16)'(16384);
        end
        if (t < -(W + 16)'(16384))
        begin
            t = -(W + 16)'(16384);
        end
        return t[15:0];
    endfunction

    logic signed [W:0] si1_reg, ci1_reg, sj1_reg, cj1_reg, sh1_reg, ch1_reg;
    logic signed [W:0] cc_reg, cs_reg, sc_reg, ss_reg;
    logic signed [W:0] p_reg [9];
    logic signed [15:0] m_reg [9];

    // First level: pair products, carry the single terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg  <= rmul((W + 1)'(ci), (W + 1)'(ch));
            cs_reg  <= rmul((W + 1)'(ci), (W + 1)'(sh));
            sc_reg  <= rmul((W + 1)'(si), (W + 1)'(ch));
            ss_reg  <= rmul((W + 1)'(si), (W + 1)'(sh));
            si1_reg <= (W + 1)'(si);
            ci1_reg <= (W + 1)'(ci);
            sj1_reg <= (W + 1)'(sj);
            cj1_reg <= (W + 1)'(cj);
            sh1_reg <= (W + 1)'(sh);
            ch1_reg <= (W + 1)'(ch);
        end
    end

    // Second level: triple products and sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= rmul(sj1_reg, ss_reg) + cc_reg;
            p_reg[1] <= rmul(cj1_reg, sh1_reg);
            p_reg[2] <= rmul(sj1_reg, cs_reg) - sc_reg;
            p_reg[3] <= rmul(sj1_reg, sc_reg) - cs_reg;
            p_reg[4] <= rmul(cj1_reg, ch1_reg);
            p_reg[5] <= rmul(sj1_reg, cc_reg) + ss_reg;
            p_reg[6] <= rmul(cj1_reg, si1_reg);
            p_reg[7] <= -sj1_reg;
            p_reg[8] <= rmul(cj1_reg, ci1_reg);
        end
    end

    // Third level: scale to Q1.14 and saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                m_reg[k] <= to_out((W + 2)'(p_reg[k]));
            end
        end
    end

    assign m = m_reg;

endmodule

// ----- rtl/rotation_matrix_from_euler.sv -----
// Top level: euler angles in, 3x3 rotation matrix out
//
// Use: drive s_axis_tdata with mode, roll, pitch and yaw; one item is taken
// per cycle when s_axis_tvalid and s_axis_tready are high. Each item yields
// one matrix item on m_axis_tdata, nine Q1.14 entries, row major.
// Pipeline from the accepting edge to output valid: two phase levels, the
// cell row input register, one register per cell and three product levels.
// Throughput: one item per clock while the output is not stalled; the
// pipeline is a row of CORDIC cells with one cell per rotation step,
// followed by three product levels.
// Stall: the whole pipeline holds when the output item waits and
// m_axis_tready is low; s_axis_tready is then low too, since a waiting
// result freezes every stage.
// Reset: rst_n clears the valid bits of all stages; payload is not cleared.
// The block holds no state between items.
//
module rotation_matrix_from_euler
    import rmfe_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int COEF_BITS     = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // mode[0], roll[16:1], pitch[32:17], yaw[48:33], zero fill
    input  logic [TDATA_IN_BITS-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // m_r0c0[15:0] .. m_r2c2[143:128], 16 bits each
    output logic [TDATA_OUT_BITS-1:0] m_axis_tdata
);

`include "rotation_matrix_from_euler_defines.svh"

    localparam int NS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = NS + 6;
    localparam int CF  = COEF_BITS - 2;

    logic en;
    logic [LAT-1:0] vld_reg;

    // Advance when the last stage is empty or being taken
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    // Track item valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // Convert the three angles; pitch and roll are negated
    logic [PHASE_BITS-1:0] ph [3];
    rmfe_phase #(.ANGLE_BITS(ANGLE_BITS)) u_ph_yaw (
        .clk(clk), .en(en), .mode(s_axis_tdata[0]),
        .angle(s_axis_tdata[48:33]), .negate(1'b0), .phase(ph[0]));
    rmfe_phase #(.ANGLE_BITS(ANGLE_BITS)) u_ph_pitch (
        .clk(clk), .en(en), .mode(s_axis_tdata[0]),
        .angle(s_axis_tdata[32:17]), .negate(1'b1), .phase(ph[1]));
    rmfe_phase #(.ANGLE_BITS(ANGLE_BITS)) u_ph_roll (
        .clk(clk), .en(en), .mode(s_axis_tdata[0]),
        .angle(s_axis_tdata[16:1]), .negate(1'b1), .phase(ph[2]));

    // Split into quadrant and residual
    logic signed [ACC_BITS-1:0] xs [NS+1][3];
    logic signed [ACC_BITS-1:0] ys [NS+1][3];
    logic signed [ACC_BITS-1:0] zs [NS+1][3];
    logic [1:0]                 qs [NS+1][3];
    logic [1:0]                 q0 [3];
    logic [PHASE_BITS-1:0]      d0 [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q0[k] = 2'((ph[k] + 32'h2000_0000) >> 30);
            d0[k] = ph[k] - {q0[k], 30'd0};
        end
    end

    // Hold the cell row input in registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                xs[0][k] <= GAIN_Q30;
                ys[0][k] <= '0;
                zs[0][k] <= ACC_BITS'(signed'(d0[k]));
                qs[0][k] <= q0[k];
            end
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        rmfe_cordic_cell #(.STAGE(g)) u_cell (
            .clk(clk), .en(en),
            .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]), .q_in(qs[g]),
            .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1]), .q_out(qs[g+1]));
    end

    // Round to coefficient width and apply the quadrant
    logic signed [COEF_BITS:0] sn [3];
    logic signed [COEF_BITS:0] cs [3];
    logic signed [ACC_BITS-1:0] cr, sr;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cr = (xs[NS][k] + (ACC_BITS'(1) <<< (29 - CF))) >>> (30 - CF);
            sr = (ys[NS][k] + (ACC_BITS'(1) <<< (29 - CF))) >>> (30 - CF);
            unique case (qs[NS][k])
                2'd0:
                begin
                    cs[k] = (COEF_BITS + 1)'(cr);
                    sn[k] = (COEF_BITS + 1)'(sr);
                end
                2'd1:
                begin
                    cs[k] = (COEF_BITS + 1)'(-sr);
                    sn[k] = (COEF_BITS + 1)'(cr);
                end
                2'd2:
                begin
                    cs[k] = (COEF_BITS + 1)'(-cr);
                    sn[k] = (COEF_BITS + 1)'(-sr);
                end
                default:
                begin
                    cs[k] = (COEF_BITS + 1)'(sr);
                    sn[k] = (COEF_BITS + 1)'(-cr);
                end
            endcase
        end
    end

    logic signed [15:0] m [9];
    rmfe_matrix #(.COEF_BITS(COEF_BITS)) u_mat (
        .clk(clk), .en(en),
        .si(sn[0]), .ci(cs[0]), .sj(sn[1]), .cj(cs[1]), .sh(sn[2]), .ch(cs[2]),
        .m(m));

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_axis_tdata[16*k +: 16] = m[k];
        end
    end

    `RMFE_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready,
        "input stalled while output empty")
    `RMFE_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output item changed under stall")
    `RMFE_ASSERT_NEXT(a_freeze_valid, clk, rst_n, !en, $stable(vld_reg),
        "pipeline moved while frozen")

endmodule

// ----- dv/tb.sv -----
// Testbench for the euler-angle to rotation-matrix block
module tb;
    import rmfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 21;
    localparam int MAX_CYC   = 400000;
    localparam int IDLE_MAX  = 13;
    localparam logic MODE_RAD = 1'b0;
    localparam logic MODE_DEG = 1'b1;

    typedef logic [TDATA_OUT_BITS-1:0] matrix_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [TDATA_IN_BITS-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [TDATA_OUT_BITS-1:0] m_axis_tdata;

    matrix_t matrix_q[$];
    int      err_cnt;
    int      cyc_cnt;
    bit      hold_off;
    bit      rdy_idle;

    rotation_matrix_from_euler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor shift and half-up rounding on wide signed values
    function automatic longint rnd_shift(longint v, int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] angle_phase(logic signed [15:0] a, logic deg);
        longint p;
        logic [31:0] ph;
        p = rnd_shift(longint'(a) * (deg ? 64'sd12216795864 : 64'sd10937044409), 16);
        ph = p[31:0];
        ph = (ph + 32'h0000_8000) & 32'hFFFF_0000;
        return ph;
    endfunction

    function automatic void sin_cos(logic [31:0] ph, output longint sn, output longint cs);
        logic [1:0]  q;
        logic [31:0] d;
        longint x, y, z, dx, dy, c, s;
        logic [31:0] tab [32];
        tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
                32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
                32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
                32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        q = 2'((ph + 32'h2000_0000) >> 30);
        d = ph - {q, 30'd0};
        z = longint'($signed(d));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(tab[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(tab[i]);
            end
        end
        c = rnd_shift(x, 16);
        s = rnd_shift(y, 16);
        case (q)
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shift(a * b, 14);
    endfunction

    function automatic logic [15:0] clamp_unit(longint v);
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v[15:0];
    endfunction

    // Expected matrix for one item of angles
    function automatic matrix_t rotation_of(logic deg, logic signed [15:0] roll,
                                            logic signed [15:0] pitch,
                                            logic signed [15:0] yaw);
        longint si, ci, sj, cj, sh, ch, cc, cs, sc, ss;
        matrix_t m;
        sin_cos(angle_phase(yaw, deg), si, ci);
        sin_cos(32'd0 - angle_phase(pitch, deg), sj, cj);
        sin_cos(32'd0 - angle_phase(roll, deg), sh, ch);
        cc = qmul(ci, ch);
        cs = qmul(ci, sh);
        sc = qmul(si, ch);
        ss = qmul(si, sh);
        m[15:0]    = clamp_unit(qmul(sj, ss) + cc);
        m[31:16]   = clamp_unit(qmul(cj, sh));
        m[47:32]   = clamp_unit(qmul(sj, cs) - sc);
        m[63:48]   = clamp_unit(qmul(sj, sc) - cs);
        m[79:64]   = clamp_unit(qmul(cj, ch));
        m[95:80]   = clamp_unit(qmul(sj, cc) + ss);
        m[111:96]  = clamp_unit(qmul(cj, si));
        m[127:112] = clamp_unit(-sj);
        m[143:128] = clamp_unit(qmul(cj, ci));
        return m;
    endfunction

    // Send one item after a random gap, hold until accepted
    task automatic send_angles(logic deg, logic [15:0] roll, logic [15:0] pitch,
                               logic [15:0] yaw, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, IDLE_MAX);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // drop valid only when a gap follows
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, yaw, pitch, roll, deg};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        matrix_q.push_back(rotation_of(deg, roll, pitch, yaw));
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (matrix_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic test_directed();
        logic [15:0] edges [6];
        edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h1922};
        for (int u = 0; u < 2; u++)
            for (int k = 0; k < 6; k++)
                send_angles(u[0], edges[k], edges[(k + 1) % 6], edges[(k + 3) % 6]);
        // degrees: right angles and gimbal lock at pitch of ninety
        send_angles(MODE_DEG, 16'd5760, 16'd0, 16'd0);
        send_angles(MODE_DEG, 16'd0, 16'd5760, 16'd0);
        send_angles(MODE_DEG, 16'd0, 16'd0, 16'd5760);
        send_angles(MODE_DEG, 16'd2880, -16'sd5760, 16'd11520);
        send_angles(MODE_RAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // pause until every matrix has arrived
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [15:0] a [3];
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 3; k++)
                case ($urandom_range(0, 3))
                    0: a[k] = 16'($urandom_range(0, 65535));
                    1: a[k] = 16'($signed(16'($urandom_range(0, 2 * 12868))) - 12868);
                    2: a[k] = 16'($signed(16'($urandom_range(0, 2 * 11520))) - 11520);
                    default: a[k] = 16'($urandom_range(0, 16)) << $urandom_range(0, 12);
                endcase
            send_angles(1'($urandom_range(0, 1)), a[0], a[1], a[2]);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 60; n++)
            send_angles(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                        16'($urandom), 1);
        drain_results();
    endtask

    // Receiver: random stalls, plus a long hold-off counted in cycles
    always @(negedge clk)
    begin
        if (hold_off)
        begin
            m_axis_tready <= 1'b0;
            repeat (200) @(negedge clk);
            hold_off = 1'b0;
        end
        else if (m_axis_tvalid && !m_axis_tready && !rdy_idle)
        begin
            rdy_idle = 1'b1;
            repeat ($urandom_range(0, IDLE_MAX)) @(negedge clk);
            m_axis_tready <= 1'b1;
        end
        else if (m_axis_tready && $urandom_range(0, 3) == 0)
            m_axis_tready <= 1'b0;
        else
        begin
            rdy_idle = 1'b0;
            if (!m_axis_tvalid && !m_axis_tready)
                m_axis_tready <= 1'b1;
        end
    end

    // Check each matrix against the oldest expectation
    always @(posedge clk)
    begin
        matrix_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (matrix_q.size() == 0)
            begin
                $display("%0t: unexpected matrix %h", $time, m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                want = matrix_q.pop_front();
                for (int e = 0; e < 9; e++)
                    if (m_axis_tdata[16*e +: 16] !== want[16*e +: 16])
                    begin
                        $display("%0t: entry r%0dc%0d expected %0d actual %0d", $time,
                                 e / 3, e % 3, $signed(want[16*e +: 16]),
                                 $signed(m_axis_tdata[16*e +: 16]));
                        err_cnt++;
                    end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cyc_cnt++;
        if (cyc_cnt > MAX_CYC)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        err_cnt       = 0;
        cyc_cnt       = 0;
        hold_off      = 1'b0;
        rdy_idle      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(800);
        test_backpressure();
        test_random(770);
        drain_results();
        if (err_cnt == 0 && matrix_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
